/* design/uvsa_pkg.sv */
// ---------------------------------------------------------------------------
// uvsa_pkg
// Shared widths, register indexes, state codes and the link type that
// passes between neighboring cells of the sorted chain.
// ---------------------------------------------------------------------------
package uvsa_pkg;

   localparam int VALUE_W    = 32;
   localparam int TOL_W      = 8;
   localparam int LIMIT_W    = 5;
   localparam int POS_W      = 6;
   localparam int SLOT_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_TOL    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIQUE_LIMIT = 1'b1;

   localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_ERROR,
      ST_READ,
      ST_EMIT
   } state_type;

   // value held by a cell and whether it sits at or past the insert point
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      pos;
   } link_type;

endpackage

/* design/uvsa_cell.sv */
// ---------------------------------------------------------------------------
// uvsa_cell
// One entry of the sorted unique list. Compares its value against the
// probe, and on an insert either keeps, takes the probe or takes the
// value of its lower neighbor.
// ---------------------------------------------------------------------------
module uvsa_cell (
   input  logic                               clock,
   input  logic                               ins_en,
   input  logic                               occupied,
   input  logic signed [uvsa_pkg::VALUE_W-1:0] probe,
   input  logic [uvsa_pkg::TOL_W-1:0]         tol,
   input  uvsa_pkg::link_type                 link_in,
   output uvsa_pkg::link_type                 link_out,
   output logic                               match
);

   logic signed [uvsa_pkg::VALUE_W-1:0] value_ff;
   logic signed [uvsa_pkg::VALUE_W-1:0] value_in;
   logic signed [uvsa_pkg::VALUE_W:0]   diff;
   logic signed [uvsa_pkg::VALUE_W:0]   tol_ext;
   logic                                at_pos;

   always_comb begin
      diff     = {value_ff[uvsa_pkg::VALUE_W-1], value_ff}
               - {probe[uvsa_pkg::VALUE_W-1], probe};
      tol_ext  = $signed({{(uvsa_pkg::VALUE_W + 1 - uvsa_pkg::TOL_W){1'b0}}, tol});
      match    = occupied && (diff <= tol_ext) && (diff >= -tol_ext);
      at_pos   = !occupied || (value_ff > probe);
      link_out.value = value_ff;
      link_out.pos   = at_pos;

      value_in = value_ff;
      if (ins_en) begin
         // shift up when the neighbor below is already past the insert point
         if (link_in.pos) begin
            value_in = link_in.value;
         end else if (at_pos) begin
            value_in = probe;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* design/uvsa_pos_store.sv */
// ---------------------------------------------------------------------------
// uvsa_pos_store
// Value store indexed by sequence position, one write and one registered
// read per cycle.
// ---------------------------------------------------------------------------
module uvsa_pos_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic signed [uvsa_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]                      rd_addr,
   output logic signed [uvsa_pkg::VALUE_W-1:0] rd_data
);

   logic signed [uvsa_pkg::VALUE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/unique_value_slot_assigner_unit.sv */
// ---------------------------------------------------------------------------
// unique_value_slot_assigner_unit
// Collects a run of signed Q8.24 values into a sorted list of unique values
// (a row of insertion cells) and a by-position store, then reports for each
// position its first matching sorted slot and the sorted value at that index.
// ---------------------------------------------------------------------------
//
//  channel  dir  payload                                            marker
//  req_     in   tdata: value[31:0]                                 tlast: last
//  rsp_     out  tdata: position, slot, unique_value, unique_valid,  tlast: end_of_run
//                       unique_count; tuser: error
//  csr_     in   index 0 match_tolerance, 1 unique_limit            write only
//
//  one input item per cycle while collecting; the chain compares and inserts
//  in the same cycle the item is taken.
//  after the last item each result passes the position store read, then the
//  chain lookup into the output register; an error run gives one result.
//  reset clears counters, overflow flag and output valid; no clearing pass.
//  a stalled result holds the output register; input is taken again as soon
//  as the final result of a run is loaded.
// ---------------------------------------------------------------------------
module unique_value_slot_assigner_unit #(
   parameter int UNIQUE_DEPTH = 16,
   parameter int MAX_SEQUENCE = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // value
   input  logic [uvsa_pkg::VALUE_W-1:0]         req_tdata,
   input  logic                                 req_tlast,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // position[5:0], slot[9:6], unique_value[41:10], unique_valid[42],
   // unique_count[47:43]
   output logic [uvsa_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // error[0]
   output logic [0:0]                           rsp_tuser,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic                                 csr_we,
   input  logic [uvsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [uvsa_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int UTW  = $clog2(UNIQUE_DEPTH + 1);
   localparam int PTW  = $clog2(MAX_SEQUENCE + 1);
   localparam int PAW  = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
   localparam int MAXV = (UNIQUE_DEPTH > MAX_SEQUENCE) ? UNIQUE_DEPTH : MAX_SEQUENCE;
   localparam int CW   = $clog2(((MAXV > 32) ? MAXV : 32) + 1) + 1;

   uvsa_pkg::state_type                 state_ff, state_in;
   logic [uvsa_pkg::TOL_W-1:0]          tol_ff, tol_in;
   logic [uvsa_pkg::LIMIT_W-1:0]        limit_ff, limit_in;
   logic [UTW-1:0]                      utot_ff, utot_in;
   logic [PTW-1:0]                      ptot_ff, ptot_in;
   logic [PAW-1:0]                      p_ff, p_in;
   logic                                ovf_ff, ovf_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [uvsa_pkg::RSP_DATA_W-1:0]     rsp_tdata_ff, rsp_tdata_in;
   logic [0:0]                          rsp_tuser_ff, rsp_tuser_in;
   logic                                rsp_tlast_ff, rsp_tlast_in;

   logic signed [uvsa_pkg::VALUE_W-1:0] probe;
   logic signed [uvsa_pkg::VALUE_W-1:0] rd_data;
   uvsa_pkg::link_type                  link_q [UNIQUE_DEPTH];
   logic [UNIQUE_DEPTH-1:0]             match_vec;
   logic [UNIQUE_DEPTH-1:0]             occ_vec;
   logic                                ins_en;
   logic                                wr_en;
   logic                                acc;
   logic                                absorb;
   logic                                any_match;
   logic                                seq_full;
   logic                                list_full;
   logic                                out_free;
   logic                                last_pos;
   logic                                uv_valid;
   logic [CW-1:0]                       cap;
   logic [uvsa_pkg::SLOT_W-1:0]         first_slot;
   logic signed [uvsa_pkg::VALUE_W-1:0] sel_value;

   assign probe = (state_ff == uvsa_pkg::ST_COLLECT) ? $signed(req_tdata) : rd_data;

   // sorted insertion chain
   for (genvar i = 0; i < UNIQUE_DEPTH; i++) begin : g_cell
      uvsa_pkg::link_type link_in;
      assign occ_vec[i] = CW'(i) < CW'(utot_ff);
      if (i == 0) begin : g_head
         assign link_in = '0;
      end else begin : g_body
         assign link_in = link_q[i-1];
      end
      uvsa_cell u_cell (
         .clock    (clock),
         .ins_en   (ins_en),
         .occupied (occ_vec[i]),
         .probe    (probe),
         .tol      (tol_ff),
         .link_in  (link_in),
         .link_out (link_q[i]),
         .match    (match_vec[i])
      );
   end

   uvsa_pos_store #(
      .DEPTH (MAX_SEQUENCE),
      .AW    (PAW)
   ) u_pos_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ptot_ff[PAW-1:0]),
      .wr_data ($signed(req_tdata)),
      .rd_addr (p_ff),
      .rd_data (rd_data)
   );

   // lowest matching slot and value at index p
   always_comb begin
      first_slot = '0;
      for (int i = UNIQUE_DEPTH - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            first_slot = uvsa_pkg::SLOT_W'(i);
         end
      end
      sel_value = '0;
      for (int i = 0; i < UNIQUE_DEPTH; i++) begin
         if (CW'(p_ff) == CW'(i)) begin
            sel_value = link_q[i].value;
         end
      end
   end

   always_comb begin
      any_match  = |match_vec;
      cap        = (CW'(limit_ff) < CW'(UNIQUE_DEPTH)) ? CW'(limit_ff) : CW'(UNIQUE_DEPTH);
      list_full  = CW'(utot_ff) >= cap;
      seq_full   = CW'(ptot_ff) >= CW'(MAX_SEQUENCE);
      req_tready = (state_ff == uvsa_pkg::ST_COLLECT);
      acc        = req_tvalid && req_tready;
      absorb     = acc && !ovf_ff;
      wr_en      = absorb && !seq_full;
      ins_en     = wr_en && !any_match && !list_full;
      out_free   = !rsp_tvalid_ff || rsp_tready;
      last_pos   = (CW'(p_ff) + CW'(1)) == CW'(ptot_ff);
      uv_valid   = CW'(p_ff) < CW'(utot_ff);

      tol_in   = tol_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            uvsa_pkg::CSR_MATCH_TOL:    tol_in   = csr_wdata[uvsa_pkg::TOL_W-1:0];
            uvsa_pkg::CSR_UNIQUE_LIMIT: limit_in = csr_wdata[uvsa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      state_in = state_ff;
      p_in     = p_ff;
      utot_in  = utot_ff + UTW'(ins_en);
      ptot_in  = ptot_ff + PTW'(wr_en);
      ovf_in   = ovf_ff;
      if (absorb && (seq_full || (!any_match && list_full))) begin
         ovf_in = 1'b1;
      end

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         uvsa_pkg::ST_COLLECT: begin
            if (acc && req_tlast) begin
               p_in     = '0;
               state_in = ovf_in ? uvsa_pkg::ST_ERROR : uvsa_pkg::ST_READ;
            end
         end
         uvsa_pkg::ST_ERROR: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = '0;
               rsp_tuser_in  = 1'b1;
               rsp_tlast_in  = 1'b1;
               utot_in       = '0;
               ptot_in       = '0;
               ovf_in        = 1'b0;
               state_in      = uvsa_pkg::ST_COLLECT;
            end
         end
         uvsa_pkg::ST_READ: begin
            state_in = uvsa_pkg::ST_EMIT;
         end
         uvsa_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {uvsa_pkg::COUNT_W'(utot_ff),
                                uv_valid,
                                uv_valid ? sel_value : '0,
                                first_slot,
                                uvsa_pkg::POS_W'(p_ff)};
               rsp_tuser_in  = 1'b0;
               rsp_tlast_in  = last_pos;
               if (last_pos) begin
                  utot_in  = '0;
                  ptot_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = uvsa_pkg::ST_COLLECT;
               end else begin
                  p_in     = p_ff + PAW'(1);
                  state_in = uvsa_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = uvsa_pkg::ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= uvsa_pkg::ST_COLLECT;
         tol_ff        <= uvsa_pkg::TOL_RESET;
         limit_ff      <= uvsa_pkg::LIMIT_RESET;
         utot_ff       <= '0;
         ptot_ff       <= '0;
         p_ff          <= '0;
         ovf_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tol_ff        <= tol_in;
         limit_ff      <= limit_in;
         utot_ff       <= utot_in;
         ptot_ff       <= ptot_in;
         p_ff          <= p_in;
         ovf_ff        <= ovf_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule
